FILE: sv/lzrd_pkg.sv
// Shared types and defaults for the LZ/RLE byte decompressor.
package lzrd_pkg;

  localparam int DEF_WINDOW_DEPTH = 2048;

  // One result transaction as it leaves the decoder.
  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       wants_byte;
    logic [1:0] status;
  } result_t;

endpackage

FILE: sv/lzrd_window.sv
// History window: synchronous-read RAM with write-to-read forwarding.
module lzrd_window #(
  parameter int DEPTH = lzrd_pkg::DEF_WINDOW_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] q;
  logic       fwd;
  logic [7:0] fwd_data;

  // RAM returns old data on a same-address collision; the bypass covers it.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q        <= mem[raddr];
    fwd_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= we && (waddr == raddr);
    end
  end

  assign rdata = fwd ? fwd_data : q;

endmodule

FILE: sv/lzrd_out_fifo.sv
// Two-entry result queue between the decoder and the master stream port.
module lzrd_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lzrd_pkg::result_t push_data,
  output logic              space,
  output logic              m_tvalid,
  input  logic              m_tready,
  output lzrd_pkg::result_t pop_data
);
  import lzrd_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign space    = (count != 2'd2);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/lz_rle_byte_decompressor_core.sv
// Top level of the LZ77 / run-length byte decompressor.
//
// Channel  Dir  Signals                          Contents (low bit first)
// -------  ---  -------------------------------  ---------------------------------------
// s        in   s_tvalid s_tready s_tdata        tdata: in_byte[7:0]
//               s_tuser s_tlast                  tuser: func (0 feed, 1 pull); tlast: in_last
// m        out  m_tvalid m_tready m_tdata        tdata: out_byte[7:0], wants_byte[8],
//               m_tuser                                 status[10:9], zero [15:11]
//                                                tuser: out_valid
// cfg      in   cfg_we cfg_wdata                 max_output_size[15:0]
//
// One input transaction per clock, back to back while the result queue has space; its
// result enters the queue at the accepting edge and is offered on m behind older ones.
// Back-reference pulls prefetch from the history RAM; a bypass covers an offset of one.
// Reset is synchronous and clears control state only; the history RAM is never
// read before written since offsets are checked against the decoded count.
// Two-entry result queue: s_tready drops only while both entries are occupied.
module lz_rle_byte_decompressor_core #(
  parameter int WINDOW_DEPTH = lzrd_pkg::DEF_WINDOW_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // packed byte / pull request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tuser,   // func
  input  logic        s_tlast,   // in_last
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_byte, wants_byte, status, zero pad
  output logic        m_tuser,   // out_valid
  // size limit register
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import lzrd_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  localparam logic [15:0] MAX_OUT_RESET = 16'hC000;

  // decoder phases
  localparam logic [3:0] PH_CMD       = 4'd0;
  localparam logic [3:0] PH_BR_OFFSET = 4'd1;
  localparam logic [3:0] PH_BR_EXTRA  = 4'd2;
  localparam logic [3:0] PH_RUN_LEN   = 4'd3;
  localparam logic [3:0] PH_FILL_VAL  = 4'd4;
  localparam logic [3:0] PH_COPY_LEN  = 4'd5;
  localparam logic [3:0] PH_LITERAL   = 4'd6;
  localparam logic [3:0] PH_FILL_OUT  = 4'd7;
  localparam logic [3:0] PH_BACK_OUT  = 4'd8;

  // status codes
  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  // command low-nibble codes (odd ones; even codes are back-references)
  localparam logic [3:0] CMD_RUN_LONG  = 4'h1;
  localparam logic [3:0] CMD_END       = 4'h3;
  localparam logic [3:0] CMD_LIT_SHORT = 4'h5;
  localparam logic [3:0] CMD_RUN_SHORT = 4'h9;
  localparam logic [3:0] CMD_FILL2     = 4'hB;
  localparam logic [3:0] CMD_LIT_LONG  = 4'hD;

  // state registers
  logic [15:0]   max_output_size;
  logic [AW-1:0] write_pos, write_pos_next;
  logic [15:0]   decoded_count, decoded_count_next;
  logic [3:0]    phase, phase_next;
  logic [12:0]   remaining, remaining_next;
  logic [7:0]    fill_value, fill_value_next;
  logic [10:0]   back_offset, back_offset_next;
  logic [3:0]    command_nibble, command_nibble_next;
  logic [1:0]    outcome, outcome_next;

  logic          accept;
  logic          pulling;
  logic          put;
  logic [7:0]    obyte;
  logic          ovalid;
  logic [3:0]    lo;
  logic [3:0]    hi;
  logic [10:0]   off_sum;
  logic          sb_do;
  logic [10:0]   sb_off;
  logic [12:0]   sb_len;
  logic [12:0]   rem_dec;
  logic [AW:0]   rd_diff;
  logic [AW-1:0] rd_addr;
  logic [7:0]    win_rdata;
  logic          q_space;
  result_t       res_in;
  result_t       res_out;

  assign accept  = s_tvalid && s_tready;
  assign s_tready = q_space;
  assign pulling = (phase == PH_FILL_OUT) || (phase == PH_BACK_OUT);
  assign lo      = s_tdata[3:0];
  assign hi      = s_tdata[7:4];
  assign off_sum = back_offset + {3'b000, s_tdata};

  always_comb begin
    write_pos_next      = write_pos;
    decoded_count_next  = decoded_count;
    phase_next          = phase;
    remaining_next      = remaining;
    fill_value_next     = fill_value;
    back_offset_next    = back_offset;
    command_nibble_next = command_nibble;
    outcome_next        = outcome;
    put                 = 1'b0;
    obyte               = 8'd0;
    ovalid              = 1'b0;
    sb_do               = 1'b0;
    sb_off              = back_offset;
    sb_len              = 13'd2;
    rem_dec             = 13'd0;

    if (accept && (outcome == ST_RUNNING)) begin
      if (!s_tuser && !pulling) begin
        if (phase == PH_CMD) begin
          if (decoded_count >= max_output_size) begin
            outcome_next = ST_ERROR;
          end else if (lo == CMD_END) begin
            outcome_next = ST_FINISHED;
          end else if (s_tlast) begin
            outcome_next = ST_ERROR;
          end else begin
            command_nibble_next = hi;
            if (!lo[0]) begin
              back_offset_next = {lo, 7'd0};
              phase_next       = PH_BR_OFFSET;
            end else begin
              unique case (lo)
                CMD_RUN_LONG: begin
                  phase_next = PH_RUN_LEN;
                end
                CMD_LIT_SHORT: begin
                  remaining_next = {9'd0, hi} + 13'd1;
                  phase_next     = PH_LITERAL;
                end
                CMD_RUN_SHORT: begin
                  remaining_next = {9'd0, hi} + 13'd3;
                  phase_next     = PH_FILL_VAL;
                end
                CMD_FILL2: begin
                  fill_value_next = {4'd0, hi} - 8'd1;
                  remaining_next  = 13'd2;
                  phase_next      = PH_FILL_OUT;
                end
                CMD_LIT_LONG: begin
                  phase_next = PH_COPY_LEN;
                end
                default: begin
                  // two-byte back-reference, offset from the top five bits
                  sb_do  = 1'b1;
                  sb_off = {6'd0, s_tdata[7:3]};
                  sb_len = 13'd2;
                end
              endcase
            end
          end
        end else if (s_tlast) begin
          outcome_next = ST_ERROR;
        end else begin
          unique case (phase)
            PH_BR_OFFSET: begin
              if (command_nibble == 4'hF) begin
                back_offset_next = off_sum;
                if ((off_sum == 11'd0) || ({5'd0, off_sum} > decoded_count)) begin
                  outcome_next = ST_ERROR;
                end else begin
                  phase_next = PH_BR_EXTRA;
                end
              end else begin
                sb_do  = 1'b1;
                sb_off = off_sum;
                sb_len = {9'd0, command_nibble} + 13'd3;
              end
            end
            PH_BR_EXTRA: begin
              sb_do  = 1'b1;
              sb_off = back_offset;
              sb_len = {5'd0, s_tdata} + 13'd18;
            end
            PH_RUN_LEN: begin
              remaining_next = {1'b0, command_nibble, s_tdata} + 13'd3;
              phase_next     = PH_FILL_VAL;
            end
            PH_FILL_VAL: begin
              fill_value_next = s_tdata;
              phase_next      = PH_FILL_OUT;
            end
            PH_COPY_LEN: begin
              remaining_next = {1'b0, command_nibble, s_tdata} + 13'd1;
              phase_next     = PH_LITERAL;
            end
            PH_LITERAL: begin
              ovalid = 1'b1;
              obyte  = s_tdata;
              put    = 1'b1;
            end
            default: begin
              phase_next = PH_CMD;
            end
          endcase
        end
      end else if (s_tuser && pulling) begin
        ovalid = 1'b1;
        obyte  = (phase == PH_FILL_OUT) ? fill_value : win_rdata;
        put    = 1'b1;
      end
    end

    // back-reference start: offset must be nonzero and within decoded data
    if (sb_do) begin
      if ((sb_off == 11'd0) || ({5'd0, sb_off} > decoded_count)) begin
        outcome_next = ST_ERROR;
      end else begin
        back_offset_next = sb_off;
        remaining_next   = sb_len;
        phase_next       = PH_BACK_OUT;
      end
    end

    // one byte into history
    if (put) begin
      write_pos_next = (write_pos == AW'(WINDOW_DEPTH - 1)) ? '0 : write_pos + 1'b1;
      if (decoded_count != 16'hFFFF) begin
        decoded_count_next = decoded_count + 16'd1;
      end
      rem_dec        = (remaining != 13'd0) ? remaining - 13'd1 : remaining;
      remaining_next = rem_dec;
      if (rem_dec == 13'd0) begin
        phase_next = PH_CMD;
      end
    end
  end

  // prefetch the byte the next back-reference pull will need
  always_comb begin
    rd_diff = {1'b0, write_pos_next} - (AW + 1)'(back_offset_next);
    if (rd_diff[AW]) begin
      rd_diff = rd_diff + (AW + 1)'(WINDOW_DEPTH);
    end
    rd_addr = rd_diff[AW-1:0];
  end

  lzrd_window #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .we    (put),
    .waddr (write_pos),
    .wdata (obyte),
    .raddr (rd_addr),
    .rdata (win_rdata)
  );

  always_comb begin
    res_in.out_valid  = ovalid;
    res_in.out_byte   = obyte;
    res_in.wants_byte = (outcome_next == ST_RUNNING) && (phase_next != PH_FILL_OUT)
                        && (phase_next != PH_BACK_OUT);
    res_in.status     = outcome_next;
  end

  lzrd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_in),
    .space     (q_space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .pop_data  (res_out)
  );

  assign m_tdata = {5'd0, res_out.status, res_out.wants_byte, res_out.out_byte};
  assign m_tuser = res_out.out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_size <= MAX_OUT_RESET;
      write_pos       <= '0;
      decoded_count   <= 16'd0;
      phase           <= PH_CMD;
      remaining       <= 13'd0;
      fill_value      <= 8'd0;
      back_offset     <= 11'd0;
      command_nibble  <= 4'd0;
      outcome         <= ST_RUNNING;
    end else begin
      if (cfg_we) begin
        max_output_size <= cfg_wdata;
      end
      write_pos      <= write_pos_next;
      decoded_count  <= decoded_count_next;
      phase          <= phase_next;
      remaining      <= remaining_next;
      fill_value     <= fill_value_next;
      back_offset    <= back_offset_next;
      command_nibble <= command_nibble_next;
      outcome        <= outcome_next;
    end
  end

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the LZ/RLE byte decompressor core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lzrd_pkg::*;

  localparam int WIN_DEPTH = DEF_WINDOW_DEPTH;
  localparam int WIN_BITS = $clog2(WIN_DEPTH);
  localparam bit [15:0] RESET_SIZE_LIMIT = 16'hC000;
  localparam int STALL_LIMIT = 2000;   // cycles with no transaction on either side
  localparam int ITEMS_PER_PHASE = 470;

  // Low nibble of a command byte. Even values are long back-references.
  localparam bit [3:0] CMD_LONG_RUN = 4'h1;
  localparam bit [3:0] CMD_FINISH = 4'h3;
  localparam bit [3:0] CMD_SHORT_LIT = 4'h5;
  localparam bit [3:0] CMD_NEAR_COPY = 4'h7;   // also 0xF: offset = cmd >> 3
  localparam bit [3:0] CMD_SHORT_RUN = 4'h9;
  localparam bit [3:0] CMD_PAIR_FILL = 4'hB;
  localparam bit [3:0] CMD_LONG_LIT = 4'hD;

  typedef enum bit [1:0] {
    DEC_RUNNING = 2'd0,
    DEC_FINISHED = 2'd1,
    DEC_ERROR = 2'd2
  } dec_status_e;

  typedef enum bit [3:0] {
    PH_CMD,
    PH_OFFSET,
    PH_EXTRA_LEN,
    PH_RUN_LEN,
    PH_FILL_VAL,
    PH_COPY_LEN,
    PH_LITERAL,
    PH_FILL_OUT,
    PH_BACK_OUT
  } dec_phase_e;

  typedef enum int {
    END_MARKER,
    END_TRUNCATED,
    END_BAD_OFFSET,
    END_SIZE_LIMIT
  } stream_end_e;

  // Shadow of the decoder: tracks its state per accepted input transaction and
  // holds the result transactions that must come out, oldest first.
  class decode_tracker;
    bit [7:0] window [WIN_DEPTH];
    bit [WIN_BITS-1:0] wr_pos;
    bit [15:0] produced;
    bit [15:0] size_limit;
    dec_phase_e phase;
    dec_status_e state;
    int unsigned remain;
    int unsigned boff;
    bit [7:0] fill;
    bit [3:0] hi_nib;
    result_t due_results [$];
    int unsigned faults;

    function new();
      size_limit = RESET_SIZE_LIMIT;
      phase = PH_CMD;
      state = DEC_RUNNING;
    endfunction

    function bit wants_feed();
      return state == DEC_RUNNING && phase != PH_FILL_OUT && phase != PH_BACK_OUT;
    endfunction

    function void emit_byte(bit [7:0] v);
      window[wr_pos] = v;
      wr_pos++;
      if (produced != 16'hFFFF) produced++;
      if (remain > 0) remain--;
      if (remain == 0) phase = PH_CMD;
    endfunction

    function void begin_copy(int unsigned off, int unsigned len);
      if (off == 0 || off > produced) begin
        state = DEC_ERROR;
      end else begin
        boff = off;
        remain = len;
        phase = PH_BACK_OUT;
      end
    endfunction

    function void decode_command(bit [7:0] c);
      bit [3:0] lo;
      lo = c[3:0];
      hi_nib = c[7:4];
      if (!lo[0]) begin
        boff = 128 * lo;
        phase = PH_OFFSET;
      end else begin
        case (lo)
          CMD_LONG_RUN: phase = PH_RUN_LEN;
          CMD_SHORT_LIT: begin
            remain = hi_nib + 1;
            phase = PH_LITERAL;
          end
          CMD_SHORT_RUN: begin
            remain = hi_nib + 3;
            phase = PH_FILL_VAL;
          end
          CMD_PAIR_FILL: begin
            fill = 8'(hi_nib) - 8'd1;
            remain = 2;
            phase = PH_FILL_OUT;
          end
          CMD_LONG_LIT: phase = PH_COPY_LEN;
          default: begin_copy(c[7:3], 2);
        endcase
      end
    endfunction

    function void take_input(bit pull, bit [7:0] b, bit last);
      result_t r;
      bit [WIN_BITS-1:0] idx;
      bit draining;
      r = '0;
      draining = (phase == PH_FILL_OUT || phase == PH_BACK_OUT);
      if (state == DEC_RUNNING) begin
        if (!pull && !draining) begin
          if (phase == PH_CMD) begin
            if (produced >= size_limit) state = DEC_ERROR;
            else if (b[3:0] == CMD_FINISH) state = DEC_FINISHED;
            else if (last) state = DEC_ERROR;
            else decode_command(b);
          end else if (last) begin
            state = DEC_ERROR;
          end else begin
            case (phase)
              PH_OFFSET: begin
                if (hi_nib == 4'hF) begin
                  boff += b;
                  if (boff == 0 || boff > produced) state = DEC_ERROR;
                  else phase = PH_EXTRA_LEN;
                end else begin
                  begin_copy(boff + b, hi_nib + 3);
                end
              end
              PH_EXTRA_LEN: begin_copy(boff, 18 + b);
              PH_RUN_LEN: begin
                remain = 256 * hi_nib + b + 3;
                phase = PH_FILL_VAL;
              end
              PH_FILL_VAL: begin
                fill = b;
                phase = PH_FILL_OUT;
              end
              PH_COPY_LEN: begin
                remain = 256 * hi_nib + b + 1;
                phase = PH_LITERAL;
              end
              PH_LITERAL: begin
                r.out_valid = 1'b1;
                r.out_byte = b;
                emit_byte(b);
              end
              default: phase = PH_CMD;
            endcase
          end
        end else if (pull && draining) begin
          idx = wr_pos - boff[WIN_BITS-1:0];
          r.out_byte = (phase == PH_FILL_OUT) ? fill : window[idx];
          r.out_valid = 1'b1;
          emit_byte(r.out_byte);
        end
      end
      r.wants_byte = wants_feed();
      r.status = state;
      due_results.push_back(r);
    endfunction

    function void note_miss(string field, logic [15:0] want, logic [15:0] got);
      faults++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    function void check_output(logic valid_flag, logic [15:0] d);
      result_t want;
      if (due_results.size() == 0) begin
        faults++;
        $display("%0t ns: result with nothing expected, expected none, got tuser=%b tdata=%h",
                 $time, valid_flag, d);
        return;
      end
      want = due_results.pop_front();
      if (valid_flag !== want.out_valid) note_miss("out_valid", want.out_valid, valid_flag);
      if (d[7:0] !== want.out_byte) note_miss("out_byte", want.out_byte, d[7:0]);
      if (d[8] !== want.wants_byte) note_miss("wants_byte", want.wants_byte, d[8]);
      if (d[10:9] !== want.status) note_miss("status", want.status, d[10:9]);
      if (d[15:11] !== 5'd0) note_miss("tdata pad", 16'd0, d[15:11]);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  decode_tracker tracker;
  bit [7:0] stream_bytes [$];   // packed bytes of the command being fed
  int feed_gap_pct = 8;         // chance per transaction that the sender idles
  int sink_stall_pct = 58;      // chance per cycle that the receiver stalls
  int unsigned results_seen;
  int unsigned quiet;

  lz_rle_byte_decompressor_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Monitor: everything is sampled at the rising edge, before the block's
  // registers move. Input transactions go to the tracker first so a result
  // seen at the same edge still finds its expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) tracker.size_limit = cfg_wdata;
      if (s_tvalid && s_tready) tracker.take_input(s_tuser, s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        tracker.check_output(m_tuser, m_tdata);
        results_seen++;
      end
    end
  end

  // Watchdog: a long stretch with no transaction on either side means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Receiver. Once, early on, it holds off for a long stretch so the result
  // queue fills and the block has to drop s_tready.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (64) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // One input transaction: optional idle cycles, then hold it until accepted.
  // Returns at the falling edge after acceptance, with s_tvalid still high.
  task automatic offer(input bit pull, input bit [7:0] b, input bit last);
    while ($urandom_range(99) < feed_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= pull;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Pull requests carry junk in tdata/tlast; the block must ignore both.
  task automatic pull_bytes(input int n);
    repeat (n) offer(1'b1, 8'($urandom), 1'($urandom));
  endtask

  // Stop sending, wait for every expected result, then let the pipe empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_size_limit(input bit [15:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Splits an offset into a long back-reference: even low nibble plus a byte.
  function automatic void push_long_copy(int unsigned off, bit [3:0] h);
    bit [3:0] lo;
    lo = 4'((off >> 7) & 32'hE);
    stream_bytes.push_back({h, lo});
    stream_bytes.push_back(8'(off - 128 * lo));
  endfunction

  // Appends one well-formed command with random content. Offsets never reach
  // past what has been decoded, so the stream keeps going.
  function automatic void plan_command();
    int unsigned cnt;
    int unsigned pick;
    int unsigned off;
    int unsigned cap;
    int unsigned len;
    bit [3:0] h;
    cnt = tracker.produced;
    cap = (cnt < WIN_DEPTH - 1) ? cnt : WIN_DEPTH - 1;
    pick = $urandom_range(99);
    if (cnt == 0 && pick >= 60) pick = pick % 60;   // no history to copy from yet
    h = 4'($urandom);
    if (pick < 12) begin
      stream_bytes.push_back({h, CMD_SHORT_LIT});
      repeat (h + 1) stream_bytes.push_back(8'($urandom));
    end else if (pick < 20) begin
      // long literals mostly short; a full page now and then
      h = ($urandom_range(19) == 0) ? 4'd1 : 4'd0;
      len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
      stream_bytes.push_back({h, CMD_LONG_LIT});
      stream_bytes.push_back(8'(len));
      repeat (256 * h + len + 1) stream_bytes.push_back(8'($urandom));
    end else if (pick < 30) begin
      stream_bytes.push_back({h, CMD_SHORT_RUN});
      stream_bytes.push_back(8'($urandom));
    end else if (pick < 38) begin
      h = ($urandom_range(24) == 0) ? 4'd1 : 4'd0;
      len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(24);
      stream_bytes.push_back({h, CMD_LONG_RUN});
      stream_bytes.push_back(8'(len));
      stream_bytes.push_back(8'($urandom));
    end else if (pick < 60) begin
      stream_bytes.push_back({h, CMD_PAIR_FILL});
    end else if (pick < 78) begin
      // two-byte copy; bit 3 of the command is the offset's low bit
      off = $urandom_range((cap < 31) ? cap : 31, 1);
      stream_bytes.push_back(8'((off << 3) | CMD_NEAR_COPY));
    end else begin
      case ($urandom_range(3))
        0: off = cap;
        1: off = $urandom_range((cap < 8) ? cap : 8, 1);
        default: off = $urandom_range(cap, 1);
      endcase
      push_long_copy(off, h);
      if (h == 4'hF)
        stream_bytes.push_back(8'(($urandom_range(7) == 0) ? $urandom_range(255)
                                                             : $urandom_range(15)));
    end
  endfunction

  // Well-formed stream with random content; a few transactions of the wrong
  // kind are mixed in and must be ignored.
  task automatic stream_random(input int target);
    int planned;
    planned = 0;
    while (tracker.state == DEC_RUNNING &&
           (planned < target || tracker.phase != PH_CMD || stream_bytes.size() != 0)) begin
      if ($urandom_range(99) < 3) begin
        offer(tracker.wants_feed(), 8'($urandom), 1'($urandom));
      end else if (!tracker.wants_feed()) begin
        pull_bytes(1);
        planned++;
      end else begin
        if (stream_bytes.size() == 0) plan_command();
        offer(1'b0, stream_bytes.pop_front(), 1'b0);
        planned++;
      end
    end
  endtask

  // The decoder only stops for good, so the run ends the stream once, in a
  // way picked at random.
  task automatic end_stream();
    stream_end_e how;
    int unsigned off;
    how = stream_end_e'($urandom_range(3));
    case (how)
      END_MARKER: offer(1'b0, {4'($urandom), CMD_FINISH}, 1'($urandom));
      END_TRUNCATED: begin
        // tlast on a command byte, or on a literal inside a copy
        if ($urandom_range(1)) begin
          offer(1'b0, {4'($urandom), CMD_SHORT_LIT}, 1'b1);
        end else begin
          offer(1'b0, {4'($urandom), CMD_SHORT_LIT}, 1'b0);
          offer(1'b0, 8'($urandom), 1'b1);
        end
      end
      END_BAD_OFFSET: begin
        off = tracker.produced + 1;
        case ($urandom_range(2))
          0: offer(1'b0, {4'd0, CMD_NEAR_COPY}, 1'b0);   // offset zero, short form
          1: begin
            offer(1'b0, {4'($urandom), 4'h0}, 1'b0);     // offset zero, long form
            offer(1'b0, 8'h00, 1'b0);
          end
          default: begin
            // one past the decoded count, or zero where that would not fit an offset
            if (off > WIN_DEPTH - 1) off = 0;
            push_long_copy(off, 4'($urandom));
            offer(1'b0, stream_bytes.pop_front(), 1'b0);
            offer(1'b0, stream_bytes.pop_front(), 1'b0);
          end
        endcase
      end
      default: begin
        // limit at or below the decoded count; even a finish marker errors out
        settle();
        set_size_limit($urandom_range(1) ? 16'd1 : tracker.produced);
        offer(1'b0, 8'($urandom), 1'($urandom));
      end
    endcase
    // after the stream is over every transaction is ignored
    repeat (10) offer(1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 16'h0000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Limit of one: the first command is still taken with nothing decoded.
    set_size_limit(16'd1);
    offer(1'b0, {4'd1, CMD_SHORT_LIT}, 1'b0);
    offer(1'b0, 8'h00, 1'b0);
    offer(1'b0, 8'hFF, 1'b0);
    settle();
    set_size_limit(16'hFFFF);

    // Directed: wrong-kind transactions, the shortest copy, fills, runs.
    offer(1'b1, 8'hFF, 1'b1);                  // pull while a byte is wanted
    offer(1'b0, {4'd1, CMD_NEAR_COPY}, 1'b0);  // 0x17: offset 2, two bytes
    offer(1'b0, 8'h00, 1'b1);                  // feed while a pull is wanted
    pull_bytes(2);
    offer(1'b0, {4'd0, CMD_PAIR_FILL}, 1'b0);  // fill value wraps to 0xFF
    pull_bytes(2);
    offer(1'b0, {4'd0, CMD_SHORT_RUN}, 1'b0);
    offer(1'b0, 8'h55, 1'b0);
    pull_bytes(3);
    offer(1'b0, 8'h00, 1'b0);                  // long copy, offset 5, length 3
    offer(1'b0, 8'h05, 1'b0);
    pull_bytes(3);

    // Three idling patterns, each with its own size limit.
    stream_random(ITEMS_PER_PHASE);
    settle();
    feed_gap_pct = 58;
    sink_stall_pct = 8;
    set_size_limit(16'($urandom_range(65534, 8192)));
    stream_random(ITEMS_PER_PHASE);
    settle();
    feed_gap_pct = 0;
    sink_stall_pct = 0;
    set_size_limit(16'($urandom_range(65535, 8192)));
    stream_random(ITEMS_PER_PHASE);

    end_stream();
    settle();
    repeat (8) @(negedge clk);
    if (tracker.faults == 0 && tracker.due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: lz_rle_byte_decompressor_core.f
sv/lzrd_pkg.sv
sv/lzrd_window.sv
sv/lzrd_out_fifo.sv
sv/lz_rle_byte_decompressor_core.sv
sim/tb_top.sv
